// ----- sv/sivt_pkg.sv -----
package sivt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_ASSIGN = 3'd1;
  localparam logic [2:0] OP_ADD    = 3'd2;
  localparam logic [2:0] OP_SUB    = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // -1.0 in q16.16
  localparam logic signed [31:0] MINUS_ONE_Q16 = -32'sd65536;

  typedef struct packed {
    logic [2:0]         op;
    logic [15:0]        key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               hit;
    logic               full_res;
    logic [15:0]        top_key;
    logic [4:0]         count;
  } rsp_t;

  typedef struct packed {
    logic [15:0]        key;
    logic signed [31:0] value;
  } entry_t;

endpackage

// ----- sv/sivt_alu.sv -----
module sivt_alu (
  input  logic [2:0]         op,
  input  logic signed [31:0] base,
  input  logic signed [31:0] operand,
  output logic signed [31:0] result
);
  import sivt_pkg::*;

  logic signed [32:0] sum;
  logic signed [32:0] diff;
  logic signed [31:0] sum_sat;
  logic signed [31:0] diff_sat;

  assign sum  = {base[31], base} + {operand[31], operand};
  assign diff = {base[31], base} - {operand[31], operand};

  // overflow when the two top bits disagree
  assign sum_sat  = (sum[32] != sum[31])
                    ? (sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum[31:0];
  assign diff_sat = (diff[32] != diff[31])
                    ? (diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : diff[31:0];

  always_comb begin
    case (op)
      OP_ASSIGN: result = operand;
      OP_ADD:    result = sum_sat;
      OP_SUB:    result = diff_sat;
      default:   result = base;
    endcase
  end

endmodule

// ----- sv/sparse_index_value_table.sv -----
// bounded key/value table with signed q16.16 values. each request transfer
// carries one operation (lookup, assign, saturating add, saturating subtract,
// clear) and yields exactly one response transfer with the value at the key,
// hit and full flags, the entry count and the key of the largest value above
// -1.0 (first one wins, 0 if none). the pairs sit in one memory with a
// registered read; each request scans the stored entries once, one read per
// cycle, looking for the key and building the argmax on both sides of the
// matching slot, then writes the modified entry back. the scan reads through
// the registered read port, and the next request transfer can follow in the
// cycle after the response is loaded. a new request is taken while the
// previous response still waits to be taken.
module sparse_index_value_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sivt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output sivt_pkg::rsp_t rsp
);
  import sivt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_CALC = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state;

  // key/value storage
  entry_t mem [ENTRIES];
  entry_t mem_q;
  logic   q_valid;
  logic [CNT_W-1:0] q_idx;

  logic [CNT_W-1:0] entry_cnt;
  logic [CNT_W-1:0] rd_idx;

  // latched request
  req_t cur;

  // scan results
  logic               found;
  logic [CNT_W-1:0]   slot;
  logic signed [31:0] old_val;
  logic signed [31:0] pre_val;   // best before the matching slot
  logic [15:0]        pre_key;
  logic signed [31:0] suf_val;   // best after the matching slot
  logic [15:0]        suf_key;

  // calc stage results
  logic               res_present;
  logic               res_clear;
  logic               res_hit;
  logic               res_full;
  logic signed [31:0] res_val;

  logic is_mod;
  logic tbl_full;
  logic do_insert;
  logic present;
  logic signed [31:0] base;
  logic signed [31:0] new_val;
  logic [CNT_W-1:0]   wr_slot;
  logic [15:0]        best_key;
  logic signed [31:0] best_val;
  logic [15:0]        top_key;
  logic [31:0]        cnt_wide;

  assign req_ready = (state == ST_IDLE);

  assign is_mod    = (cur.op == OP_ASSIGN) || (cur.op == OP_ADD) || (cur.op == OP_SUB);
  assign tbl_full  = (entry_cnt == CNT_W'(ENTRIES));
  assign do_insert = is_mod && !found && !tbl_full;
  assign present   = (found && (cur.op != OP_CLEAR)) || do_insert;
  assign base      = found ? old_val : 32'sd0;
  assign wr_slot   = found ? slot : entry_cnt;

  sivt_alu u_alu (
    .op      (cur.op),
    .base    (base),
    .operand (cur.value),
    .result  (new_val)
  );

  // merge prefix, modified slot and suffix in table order, strict greater
  always_comb begin
    best_val = pre_val;
    best_key = pre_key;
    if (res_present && (res_val > best_val)) begin
      best_val = res_val;
      best_key = cur.key;
    end
    if (suf_val > best_val) begin
      best_val = suf_val;
      best_key = suf_key;
    end
    top_key = res_clear ? 16'd0 : best_key;
  end

  assign cnt_wide = 32'(entry_cnt);

  // memory: one registered read, one write
  always_ff @(posedge clk) begin
    mem_q <= mem[rd_idx[IDX_W-1:0]];
    if ((state == ST_CALC) && present && is_mod) begin
      mem[wr_slot[IDX_W-1:0]] <= '{key: cur.key, value: new_val};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      entry_cnt <= '0;
      rd_idx    <= '0;
      q_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // the finish state reloads the register itself when it frees up
      if (rsp_valid && rsp_ready && (state != ST_FIN)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cur     <= req;
            rd_idx  <= '0;
            q_valid <= 1'b0;
            found   <= 1'b0;
            slot    <= '0;
            old_val <= 32'sd0;
            pre_val <= MINUS_ONE_Q16;
            pre_key <= 16'd0;
            suf_val <= MINUS_ONE_Q16;
            suf_key <= 16'd0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue side: one read per cycle until every held entry is out
          if (rd_idx != entry_cnt) begin
            q_valid <= 1'b1;
            q_idx   <= rd_idx;
            rd_idx  <= rd_idx + 1'b1;
          end else begin
            q_valid <= 1'b0;
          end
          // data side: match, or fold into the argmax on the proper side
          if (q_valid) begin
            if (!found && (mem_q.key == cur.key)) begin
              found   <= 1'b1;
              slot    <= q_idx;
              old_val <= mem_q.value;
            end else if (found) begin
              if (mem_q.value > suf_val) begin
                suf_val <= mem_q.value;
                suf_key <= mem_q.key;
              end
            end else begin
              if (mem_q.value > pre_val) begin
                pre_val <= mem_q.value;
                pre_key <= mem_q.key;
              end
            end
          end
          if ((rd_idx == entry_cnt) && !q_valid) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          res_present <= present;
          res_clear   <= (cur.op == OP_CLEAR);
          res_hit     <= found;
          res_full    <= is_mod && !found && tbl_full;
          res_val     <= present ? new_val : 32'sd0;
          if (cur.op == OP_CLEAR) begin
            entry_cnt <= '0;
          end else if (do_insert) begin
            entry_cnt <= entry_cnt + 1'b1;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the response register is free
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.result_value  <= res_val;
            rsp.hit           <= res_hit;
            rsp.full_res      <= res_full;
            rsp.top_key       <= top_key;
            rsp.count         <= cnt_wide[4:0];
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // table never grows past its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    entry_cnt <= CNT_W'(ENTRIES))
    else $error("entry count above capacity");

  // scan pointer stays within the held entries
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_idx <= entry_cnt))
    else $error("scan pointer past entry count");

  // a refused insert reports no hit and a zero value
  a_full_res: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) && res_full |-> !res_hit && (res_val == 32'sd0))
    else $error("refused insert with hit or value");

  // a clear leaves the table empty
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) && (cur.op == OP_CLEAR) |=> (entry_cnt == '0))
    else $error("clear left entries");

endmodule
